// ===== rtl/rmj_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_pkg
// constants and stage types for the radar measurement jacobian pipeline
// ----------------------------------------------------------------------------
package rmj_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 32;
    localparam int NUM_LANES   = 6;
    localparam int DEN_W       = 96;
    localparam int NUM_W       = 96 + FRAC_BITS;

    localparam logic [31:0] MIN_RANGE_SQ_RST = 32'd42950;

    // stage positions along the pipeline
    localparam int ST_A       = 0;
    localparam int ST_B       = 1;
    localparam int ST_C       = 2;
    localparam int ST_Q0      = 3;
    localparam int ST_M0      = ST_Q0 + SQRT_STEPS;
    localparam int ST_M1      = ST_M0 + 1;
    localparam int ST_M2      = ST_M1 + 1;
    localparam int ST_D0      = ST_M2 + 1;
    localparam int ST_OUT     = ST_D0 + DIV_STEPS + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    // lane order
    localparam int LN_RANGE_X   = 0;
    localparam int LN_RANGE_Y   = 1;
    localparam int LN_BEARING_X = 2;
    localparam int LN_BEARING_Y = 3;
    localparam int LN_RATE_X    = 4;
    localparam int LN_RATE_Y    = 5;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_stg_a;

    typedef struct packed {
        logic [31:0]        mpx;
        logic [31:0]        mpy;
        logic               npx;
        logic               npy;
        logic [63:0]        sxx;
        logic [63:0]        syy;
        logic signed [63:0] pvy;
        logic signed [63:0] pvx;
    } t_stg_b;

    typedef struct packed {
        logic [31:0]        mpx;
        logic [31:0]        mpy;
        logic               npx;
        logic               npy;
        logic [63:0]        s;
        logic signed [64:0] c;
        logic               tc;
    } t_stg_c;

    typedef struct packed {
        t_stg_c      base;
        logic [33:0] rem;
        logic [31:0] root;
    } t_stg_q;

    typedef struct packed {
        logic [31:0] mpx;
        logic [31:0] mpy;
        logic        npx;
        logic        npy;
        logic [63:0] s;
        logic [31:0] r;
        logic [63:0] mc;
        logic        nc;
        logic        tc;
    } t_stg_m0;

    typedef struct packed {
        logic [31:0] mpx;
        logic [31:0] mpy;
        logic        npx;
        logic        npy;
        logic        nc;
        logic        tc;
        logic [63:0] s;
        logic [31:0] r;
        logic [63:0] sr_lo;
        logic [63:0] sr_hi;
        logic [63:0] ymc_lo;
        logic [63:0] ymc_hi;
        logic [63:0] xmc_lo;
        logic [63:0] xmc_hi;
    } t_stg_m1;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } t_lane_m2;

    typedef struct packed {
        logic [DEN_W-1:0] p;
        logic [31:0]      low;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
        logic [31:0]      q;
    } t_lane_d;

    typedef struct packed {
        logic signed [31:0] range_dpx;
        logic signed [31:0] range_dpy;
        logic signed [31:0] bearing_dpx;
        logic signed [31:0] bearing_dpy;
        logic signed [31:0] rate_dpx;
        logic signed [31:0] rate_dpy;
        logic               too_close;
    } t_stg_out;

endpackage

// ===== rtl/radar_measurement_jacobian_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_top
// throughput: one state per cycle while i_stall is low, set by the 32-step pipelined
// square root and the 32-step pipelined dividers (one quotient bit per stage)
// bubbles collapse: a stage loads whenever it or any later stage is empty, or i_stall is low
// reset: synchronous active low, clears valid bits and loads the threshold
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_top
    import rmj_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_range_dpx,
    output logic signed [31:0] o_range_dpy,
    output logic signed [31:0] o_bearing_dpx,
    output logic signed [31:0] o_bearing_dpy,
    output logic signed [31:0] o_rate_dpx,
    output logic signed [31:0] o_rate_dpy,
    output logic               o_too_close,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    logic [31:0]           r_min_range_sq;
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES:0]   free;

    t_stg_a   r_a,  n_a;
    t_stg_b   r_b,  n_b;
    t_stg_c   r_c,  n_c;
    t_stg_q   r_q   [SQRT_STEPS];
    t_stg_m0  r_m0, n_m0;
    t_stg_m1  r_m1, n_m1;
    t_lane_m2 r_m2  [NUM_LANES];
    t_lane_m2 n_m2  [NUM_LANES];
    logic     r_m2_tc;
    t_lane_d  r_d   [DIV_STEPS+1][NUM_LANES];
    logic     r_d_tc [DIV_STEPS+1];
    t_stg_out r_out, n_out;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range_sq <= MIN_RANGE_SQ_RST;
        end else if (i_cfg_valid) begin
            r_min_range_sq <= i_cfg_data;
        end
    end

    // flow control
    always_comb begin
        free[NUM_STAGES] = !i_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            free[k] = !r_v[k] || free[k+1];
        end
    end

    assign o_stall = !free[0];
    assign o_valid = r_v[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (free[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (free[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage a: input register
    always_comb begin
        n_a.px = i_pos_x;
        n_a.py = i_pos_y;
        n_a.vx = i_vel_x;
        n_a.vy = i_vel_y;
    end

    // stage b: squares, cross products, magnitudes
    logic signed [63:0] prod_xx, prod_yy, prod_vy_py, prod_vx_px;

    always_comb begin
        prod_xx    = r_a.px * r_a.px;
        prod_yy    = r_a.py * r_a.py;
        prod_vy_py = r_a.vx * r_a.py;
        prod_vx_px = r_a.vy * r_a.px;
        n_b.mpx = r_a.px[31] ? $unsigned(-r_a.px) : $unsigned(r_a.px);
        n_b.mpy = r_a.py[31] ? $unsigned(-r_a.py) : $unsigned(r_a.py);
        n_b.npx = r_a.px[31];
        n_b.npy = r_a.py[31];
        n_b.sxx = $unsigned(prod_xx);
        n_b.syy = $unsigned(prod_yy);
        n_b.pvy = prod_vy_py;
        n_b.pvx = prod_vx_px;
    end

    // stage c: range squared, cross term, threshold test
    always_comb begin
        n_c.mpx = r_b.mpx;
        n_c.mpy = r_b.mpy;
        n_c.npx = r_b.npx;
        n_c.npy = r_b.npy;
        n_c.s   = r_b.sxx + r_b.syy;
        n_c.c   = 65'(r_b.pvy) - 65'(r_b.pvx);
        n_c.tc  = (n_c.s <= {32'd0, r_min_range_sq});
    end

    always_ff @(posedge i_clk) begin
        if (free[ST_A]) begin
            r_a <= n_a;
        end
        if (free[ST_B]) begin
            r_b <= n_b;
        end
        if (free[ST_C]) begin
            r_c <= n_c;
        end
    end

    // square root, one root bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        t_stg_q      prev;
        t_stg_q      n_q;
        logic [35:0] rem_sh;
        logic [35:0] trial;

        always_comb begin
            if (k == 0) begin
                prev.base = r_c;
                prev.rem  = '0;
                prev.root = '0;
            end else begin
                prev = r_q[(k == 0) ? 0 : k-1];
            end
            rem_sh = {prev.rem, prev.base.s[2*(SQRT_STEPS-1-k)+1 -: 2]};
            trial  = {2'b00, prev.root, 2'b01};
            n_q.base = prev.base;
            if (rem_sh >= trial) begin
                n_q.rem  = 34'(rem_sh - trial);
                n_q.root = {prev.root[30:0], 1'b1};
            end else begin
                n_q.rem  = rem_sh[33:0];
                n_q.root = {prev.root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (free[ST_Q0+k]) begin
                r_q[k] <= n_q;
            end
        end
    end

    // stage m0: cross term magnitude
    always_comb begin
        n_m0.mpx = r_q[SQRT_STEPS-1].base.mpx;
        n_m0.mpy = r_q[SQRT_STEPS-1].base.mpy;
        n_m0.npx = r_q[SQRT_STEPS-1].base.npx;
        n_m0.npy = r_q[SQRT_STEPS-1].base.npy;
        n_m0.s   = r_q[SQRT_STEPS-1].base.s;
        n_m0.r   = r_q[SQRT_STEPS-1].root;
        n_m0.tc  = r_q[SQRT_STEPS-1].base.tc;
        n_m0.nc  = r_q[SQRT_STEPS-1].base.c[64];
        n_m0.mc  = n_m0.nc ? 64'(-r_q[SQRT_STEPS-1].base.c)
                           : 64'(r_q[SQRT_STEPS-1].base.c);
    end

    // stage m1: partial products
    always_comb begin
        n_m1.mpx    = r_m0.mpx;
        n_m1.mpy    = r_m0.mpy;
        n_m1.npx    = r_m0.npx;
        n_m1.npy    = r_m0.npy;
        n_m1.nc     = r_m0.nc;
        n_m1.tc     = r_m0.tc;
        n_m1.s      = r_m0.s;
        n_m1.r      = r_m0.r;
        n_m1.sr_lo  = 64'(r_m0.s[31:0])  * 64'(r_m0.r);
        n_m1.sr_hi  = 64'(r_m0.s[63:32]) * 64'(r_m0.r);
        n_m1.ymc_lo = 64'(r_m0.mpy) * 64'(r_m0.mc[31:0]);
        n_m1.ymc_hi = 64'(r_m0.mpy) * 64'(r_m0.mc[63:32]);
        n_m1.xmc_lo = 64'(r_m0.mpx) * 64'(r_m0.mc[31:0]);
        n_m1.xmc_hi = 64'(r_m0.mpx) * 64'(r_m0.mc[63:32]);
    end

    // stage m2: numerators and denominators per lane
    logic [DEN_W-1:0] den_c;
    logic [DEN_W-1:0] ymc;
    logic [DEN_W-1:0] xmc;

    always_comb begin
        den_c = (DEN_W'(r_m1.sr_hi)  << 32) + DEN_W'(r_m1.sr_lo);
        ymc   = (DEN_W'(r_m1.ymc_hi) << 32) + DEN_W'(r_m1.ymc_lo);
        xmc   = (DEN_W'(r_m1.xmc_hi) << 32) + DEN_W'(r_m1.xmc_lo);

        n_m2[LN_RANGE_X].num   = NUM_W'(r_m1.mpx) << FRAC_BITS;
        n_m2[LN_RANGE_X].den   = DEN_W'(r_m1.r);
        n_m2[LN_RANGE_X].neg   = r_m1.npx;
        n_m2[LN_RANGE_Y].num   = NUM_W'(r_m1.mpy) << FRAC_BITS;
        n_m2[LN_RANGE_Y].den   = DEN_W'(r_m1.r);
        n_m2[LN_RANGE_Y].neg   = r_m1.npy;
        n_m2[LN_BEARING_X].num = NUM_W'(r_m1.mpy) << (2 * FRAC_BITS);
        n_m2[LN_BEARING_X].den = DEN_W'(r_m1.s);
        n_m2[LN_BEARING_X].neg = !r_m1.npy;
        n_m2[LN_BEARING_Y].num = NUM_W'(r_m1.mpx) << (2 * FRAC_BITS);
        n_m2[LN_BEARING_Y].den = DEN_W'(r_m1.s);
        n_m2[LN_BEARING_Y].neg = r_m1.npx;
        n_m2[LN_RATE_X].num    = NUM_W'(ymc) << FRAC_BITS;
        n_m2[LN_RATE_X].den    = den_c;
        n_m2[LN_RATE_X].neg    = r_m1.npy ^ r_m1.nc;
        n_m2[LN_RATE_Y].num    = NUM_W'(xmc) << FRAC_BITS;
        n_m2[LN_RATE_Y].den    = den_c;
        n_m2[LN_RATE_Y].neg    = !(r_m1.npx ^ r_m1.nc);
    end

    always_ff @(posedge i_clk) begin
        if (free[ST_M0]) begin
            r_m0 <= n_m0;
        end
        if (free[ST_M1]) begin
            r_m1 <= n_m1;
        end
        if (free[ST_M2]) begin
            r_m2    <= n_m2;
            r_m2_tc <= r_m1.tc;
        end
    end

    // divider setup: high part and overflow check
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_div_init
        t_lane_d          n_d0;
        logic [DEN_W-1:0] p_ext;

        always_comb begin
            p_ext      = DEN_W'(r_m2[l].num[NUM_W-1:DIV_STEPS]);
            n_d0.p     = p_ext;
            n_d0.low   = r_m2[l].num[DIV_STEPS-1:0];
            n_d0.den   = r_m2[l].den;
            n_d0.neg   = r_m2[l].neg;
            n_d0.ovf   = (p_ext >= r_m2[l].den);
            n_d0.q     = '0;
        end

        always_ff @(posedge i_clk) begin
            if (free[ST_D0]) begin
                r_d[0][l] <= n_d0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[ST_D0]) begin
            r_d_tc[0] <= r_m2_tc;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            t_lane_d        n_d;
            logic [DEN_W:0] t;

            always_comb begin
                n_d     = r_d[j-1][l];
                t       = {r_d[j-1][l].p, r_d[j-1][l].low[31]};
                n_d.low = {r_d[j-1][l].low[30:0], 1'b0};
                if (t >= {1'b0, r_d[j-1][l].den}) begin
                    n_d.p = DEN_W'(t - {1'b0, r_d[j-1][l].den});
                    n_d.q = {r_d[j-1][l].q[30:0], 1'b1};
                end else begin
                    n_d.p = t[DEN_W-1:0];
                    n_d.q = {r_d[j-1][l].q[30:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (free[ST_D0+j]) begin
                    r_d[j][l] <= n_d;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (free[ST_D0+j]) begin
                r_d_tc[j] <= r_d_tc[j-1];
            end
        end
    end

    // sign, saturation, rejection
    logic [31:0] ent [NUM_LANES];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_d_tc[DIV_STEPS]) begin
                ent[l] = '0;
            end else if (r_d[DIV_STEPS][l].neg) begin
                if (r_d[DIV_STEPS][l].ovf || r_d[DIV_STEPS][l].q > 32'h8000_0000) begin
                    ent[l] = 32'h8000_0000;
                end else begin
                    ent[l] = 32'd0 - r_d[DIV_STEPS][l].q;
                end
            end else begin
                if (r_d[DIV_STEPS][l].ovf || r_d[DIV_STEPS][l].q > 32'h7FFF_FFFF) begin
                    ent[l] = 32'h7FFF_FFFF;
                end else begin
                    ent[l] = r_d[DIV_STEPS][l].q;
                end
            end
        end
        n_out.range_dpx   = $signed(ent[LN_RANGE_X]);
        n_out.range_dpy   = $signed(ent[LN_RANGE_Y]);
        n_out.bearing_dpx = $signed(ent[LN_BEARING_X]);
        n_out.bearing_dpy = $signed(ent[LN_BEARING_Y]);
        n_out.rate_dpx    = $signed(ent[LN_RATE_X]);
        n_out.rate_dpy    = $signed(ent[LN_RATE_Y]);
        n_out.too_close   = r_d_tc[DIV_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (free[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_range_dpx   = r_out.range_dpx;
    assign o_range_dpy   = r_out.range_dpy;
    assign o_bearing_dpx = r_out.bearing_dpx;
    assign o_bearing_dpy = r_out.bearing_dpy;
    assign o_rate_dpx    = r_out.rate_dpx;
    assign o_rate_dpy    = r_out.rate_dpy;
    assign o_too_close   = r_out.too_close;

endmodule
